>>> rtl/ira_pkg.sv
// Shared constants, types and the digit-to-character map for the radix text converter.
// Used by ira_accum and integer_to_radix_ascii; depends on nothing else.
package ira_pkg;

   localparam int VALUE_BITS = 32;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int IDX_W      = $clog2(VALUE_BITS);
   localparam int CPAD_W     = 2 ** CNT_W;

   localparam int RADIX_W = 5;
   localparam int CSR_W   = 1;

   localparam logic [CSR_W-1:0] CSR_RADIX = 1'b0;
   localparam logic [CSR_W-1:0] CSR_UPPER = 1'b1;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_UPPER = 8'd65;
   localparam logic [7:0] CHAR_LOWER = 8'd97;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] DIGIT_TEN  = 8'd10;

   typedef struct packed {
      logic clear;
      logic step;
      logic bit_in;
   } acc_ctrl_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] d8;
      d8 = {4'b0000, d};
      if (d8 < DIGIT_TEN) begin
         digit_char = CHAR_ZERO + d8;
      end else begin
         digit_char = (upper ? CHAR_UPPER : CHAR_LOWER) + d8 - DIGIT_TEN;
      end
   endfunction

endpackage

>>> rtl/integer_to_radix_ascii.sv
// Top level of the integer to radix text converter: sequencer, config registers, output register.
// Instantiates ira_accum; uses ira_pkg.
//
// Converts one signed 32-bit word into its text in base 2..16 (radix register, clamped),
// most significant character first, one character per output word, the last one flagged.
// Negative words in base ten get a leading '-' and the magnitude; other bases write the
// two's-complement pattern. Each accepted word is fed MSB first through the doubling
// accumulator, one bit per step, then the read pointer is loaded; characters then leave
// one per cycle while rsp_ready is high. req_ready is high only while idle; the next word
// can be taken while the last character still waits.
module integer_to_radix_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ira_pkg::VALUE_BITS-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_character,
   output logic                                rsp_last_char,
   input  logic                                csr_we,
   input  logic [ira_pkg::CSR_W-1:0]           csr_index,
   input  logic [ira_pkg::RADIX_W-1:0]         csr_wdata
);

   localparam int N = ira_pkg::VALUE_BITS;
   localparam logic [ira_pkg::CNT_W-1:0] LAST_STEP = ira_pkg::CNT_W'(N - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_ACCUM, ST_LOAD, ST_EMIT} state_type;

   state_type                     state_ff, state_in;
   logic [ira_pkg::RADIX_W-1:0]   radix_ff;
   logic                          upper_ff;
   logic [ira_pkg::RADIX_W-1:0]   base_ff, base_in;
   logic [N-1:0]                  mag_ff, mag_in;
   logic [ira_pkg::CNT_W-1:0]     step_ff, step_in;
   logic [ira_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    char_ff, char_in;
   logic                          last_ff, last_in;

   ira_pkg::acc_ctrl_type         acc_ctrl;
   logic [3:0]                    rd_digit;
   logic [ira_pkg::CNT_W-1:0]     digit_count;
   logic [ira_pkg::RADIX_W-1:0]   base_clamp;
   logic [N-1:0]                  value_u;
   logic                          out_free;

   ira_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (acc_ctrl),
      .radix       (base_ff),
      .rd_index    (idx_ff),
      .rd_digit    (rd_digit),
      .digit_count (digit_count)
   );

   assign base_clamp = (radix_ff < ira_pkg::RADIX_MIN) ? ira_pkg::RADIX_MIN :
                       (radix_ff > ira_pkg::RADIX_MAX) ? ira_pkg::RADIX_MAX : radix_ff;
   assign value_u    = $unsigned(req_value);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      mag_in       = mag_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      char_in      = char_ff;
      last_in      = last_ff;
      acc_ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               base_in       = base_clamp;
               neg_in        = value_u[N-1] && (base_clamp == ira_pkg::RADIX_DEC);
               mag_in        = neg_in ? (~value_u + N'(1)) : value_u;
               step_in       = '0;
               acc_ctrl.clear = 1'b1;
               state_in      = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            // Feed the magnitude in MSB first.
            acc_ctrl.step   = 1'b1;
            acc_ctrl.bit_in = mag_ff[N-1];
            mag_in          = {mag_ff[N-2:0], 1'b0};
            step_in         = step_ff + ira_pkg::CNT_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            idx_in   = ira_pkg::IDX_W'(digit_count - ira_pkg::CNT_W'(1));
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  char_in = ira_pkg::CHAR_MINUS;
                  last_in = 1'b0;
                  neg_in  = 1'b0;
               end else begin
                  char_in = ira_pkg::digit_char(rd_digit, upper_ff);
                  last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - ira_pkg::IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff <= base_in;
      mag_ff  <= mag_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= ira_pkg::RADIX_RESET;
         upper_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            ira_pkg::CSR_RADIX: radix_ff <= csr_wdata;
            ira_pkg::CSR_UPPER: upper_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last_char = last_ff;

endmodule

>>> rtl/ira_accum.sv
// Digit accumulator: a row of base-b digit lanes that doubles and adds one input bit per step.
// Lane carries come from one wide add over generate/propagate vectors; uses ira_pkg.
module ira_accum (
   input  logic                         clock,
   input  logic                         reset,
   input  ira_pkg::acc_ctrl_type        ctrl,
   input  logic [ira_pkg::RADIX_W-1:0]  radix,
   input  logic [ira_pkg::IDX_W-1:0]    rd_index,
   output logic [3:0]                   rd_digit,
   output logic [ira_pkg::CNT_W-1:0]    digit_count
);

   localparam int N = ira_pkg::VALUE_BITS;

   logic [3:0]                  digit_ff [N];
   logic [3:0]                  digit_in [N];
   logic [ira_pkg::CNT_W-1:0]   count_ff;
   logic [ira_pkg::CNT_W-1:0]   count_in;

   logic [N-1:0]                gen;
   logic [N-1:0]                prop;
   logic [N:0]                  sum;
   logic [N:0]                  carry;
   logic [ira_pkg::CPAD_W-1:0]  carry_pad;

   // A lane generates when 2d >= b, propagates when 2d+1 == b.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         gen[i]  = ({digit_ff[i], 1'b0} >= radix);
         prop[i] = ({digit_ff[i], 1'b1} == radix);
      end
   end

   // Adder carries equal the lane carries: generate is 1+1, propagate is 1+0.
   assign sum   = {1'b0, gen | prop} + {1'b0, gen} + {{N{1'b0}}, ctrl.bit_in};
   assign carry = sum ^ {1'b0, gen | prop} ^ {1'b0, gen};
   assign carry_pad = {{(ira_pkg::CPAD_W - N - 1){1'b0}}, carry};

   always_comb begin
      logic [4:0] dbl;
      for (int i = 0; i < N; i++) begin
         dbl         = {digit_ff[i], carry[i]} - (carry[i+1] ? radix : 5'd0);
         digit_in[i] = dbl[3:0];
      end
      // Grow by one digit when the top lane in use carries out.
      count_in = count_ff + {{(ira_pkg::CNT_W-1){1'b0}}, carry_pad[count_ff]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.clear) begin
         count_ff <= ira_pkg::CNT_W'(1);
      end else if (ctrl.step) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (ctrl.clear) begin
            digit_ff[i] <= 4'd0;
         end else if (ctrl.step) begin
            digit_ff[i] <= digit_in[i];
         end
      end
   end

   assign rd_digit    = digit_ff[rd_index];
   assign digit_count = count_ff;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for integer_to_radix_ascii: drives value words, predicts their text.
// Depends on ira_pkg for widths and character codes, and on the top level of the block.
// Covers listed and random base settings, including clamped ones, both cases, and random idling on both sides.
module tb_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 14;
   localparam int PHASE_WORDS  = 10;
   localparam int QUIET_PHASES = 3;
   localparam int TAIL_CYCLES  = 48;
   localparam int SHOW_LIMIT   = 10;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic signed [ira_pkg::VALUE_BITS-1:0] req_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic [7:0]                            rsp_character;
   logic                                  rsp_last_char;
   logic                                  csr_we = 1'b0;
   logic [ira_pkg::CSR_W-1:0]             csr_index = ira_pkg::CSR_RADIX;
   logic [ira_pkg::RADIX_W-1:0]           csr_wdata = '0;

   // bench copy of the configuration
   logic [ira_pkg::RADIX_W-1:0] cfg_radix = ira_pkg::RADIX_RESET;
   logic                        cfg_upper = 1'b0;

   logic [ira_pkg::VALUE_BITS-1:0] pending_words[$];
   text_char_type                  expected_text[$];

   bit idle_on = 1'b1;
   int send_gap = 0;
   int sink_stall = 0;
   int cycle_count = 0;
   int error_count = 0;
   int words_sent = 0;
   int chars_checked = 0;
   int settings_run = 1;

   integer_to_radix_ascii i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Append the expected characters of one word under the current configuration.
   function automatic void queue_text_of(input logic [ira_pkg::VALUE_BITS-1:0] word);
      logic [4:0]                     base;
      logic [ira_pkg::VALUE_BITS-1:0] mag;
      logic [ira_pkg::VALUE_BITS-1:0] rem;
      logic [7:0]                     d8;
      logic [3:0]                     digits[$];
      text_char_type                  tc;
      bit                             neg;
      base = cfg_radix;
      if (base < ira_pkg::RADIX_MIN) begin
         base = ira_pkg::RADIX_MIN;
      end else if (base > ira_pkg::RADIX_MAX) begin
         base = ira_pkg::RADIX_MAX;
      end
      neg = word[ira_pkg::VALUE_BITS-1] && (base == ira_pkg::RADIX_DEC);
      mag = neg ? (~word + 1'b1) : word;
      do begin
         rem = mag % base;
         digits.push_front(rem[3:0]);
         mag = mag / base;
      end while (mag != 0);
      if (neg) begin
         tc.ch   = ira_pkg::CHAR_MINUS;
         tc.last = 1'b0;
         expected_text.push_back(tc);
      end
      for (int i = 0; i < digits.size(); i++) begin
         d8 = {4'b0000, digits[i]};
         if (d8 < ira_pkg::DIGIT_TEN) begin
            tc.ch = ira_pkg::CHAR_ZERO + d8;
         end else begin
            tc.ch = (cfg_upper ? ira_pkg::CHAR_UPPER : ira_pkg::CHAR_LOWER) + d8
                    - ira_pkg::DIGIT_TEN;
         end
         tc.last = (i == digits.size() - 1);
         expected_text.push_back(tc);
      end
   endfunction

   function automatic logic [ira_pkg::VALUE_BITS-1:0] pick_word();
      logic [ira_pkg::VALUE_BITS-1:0] w;
      case ($urandom_range(0, 6))
         0: w = $urandom_range(0, 40);
         1: w = -$urandom_range(1, 40);
         2: w = 32'h8000_0000 + $urandom_range(0, 3);
         3: w = 32'h7FFF_FFFF - $urandom_range(0, 3);
         4: w = $urandom >> $urandom_range(0, 31);
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // Driver: hold the word until accepted, predict its text at acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            queue_text_of(req_value);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_valid <= 1'b1;
               req_value <= pending_words.pop_front();
               if (idle_on && $urandom_range(0, 4) == 0) begin
                  send_gap = $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted character against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               error_count++;
               if (error_count <= SHOW_LIMIT) begin
                  $display("unexpected word: char 0x%02h last %0d", rsp_character,
                           rsp_last_char);
               end
            end else begin
               text_char_type exp_c;
               exp_c = expected_text.pop_front();
               chars_checked++;
               if (exp_c.ch !== rsp_character || exp_c.last !== rsp_last_char) begin
                  error_count++;
                  if (error_count <= SHOW_LIMIT) begin
                     $display("mismatch: expected char 0x%02h last %0d, got 0x%02h last %0d",
                              exp_c.ch, exp_c.last, rsp_character, rsp_last_char);
                  end
               end
            end
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) begin
               sink_stall = $urandom_range(1, 8);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_csr(input logic [ira_pkg::CSR_W-1:0] idx,
                            input logic [ira_pkg::RADIX_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == ira_pkg::CSR_RADIX) begin
         cfg_radix = data;
      end else begin
         cfg_upper = data[0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_format(input logic [ira_pkg::RADIX_W-1:0] base, input logic up);
      write_csr(ira_pkg::CSR_RADIX, base);
      write_csr(ira_pkg::CSR_UPPER, {ira_pkg::RADIX_W'($urandom_range(0, 15)) << 1} | up);
      settings_run++;
   endtask

   // Wait until every word is accepted and every character has come back.
   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_text.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [ira_pkg::RADIX_W:0] listed_format(input int n);
      case (n)
         0: return {5'd16, 1'b0};
         1: return {5'd2, 1'b1};
         2: return {5'd0, 1'b0};
         3: return {5'd1, 1'b1};
         4: return {5'd31, 1'b1};
         5: return {5'd17, 1'b0};
         6: return {5'd3, 1'b1};
         7: return {5'd8, 1'b0};
         default: return {5'd10, 1'b1};
      endcase
   endfunction

   initial begin
      logic [ira_pkg::RADIX_W:0] fmt;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset format: base ten, lowercase
      pending_words.push_back(32'd0);
      pending_words.push_back(32'd1);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back(32'd9);
      pending_words.push_back(32'd10);
      pending_words.push_back(-32'sd10);
      pending_words.push_back(32'h7FFF_FFFF);
      pending_words.push_back(32'h8000_0000);
      pending_words.push_back(32'd123456789);
      pending_words.push_back(-32'sd987654321);
      drain();

      set_format(5'd16, 1'b1);
      pending_words.push_back(32'd0);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back(32'h8000_0000);
      pending_words.push_back(32'hABCD_EF01);
      pending_words.push_back(32'h0012_3456);
      drain();

      set_format(5'd2, 1'b0);
      pending_words.push_back(32'd0);
      pending_words.push_back(32'd1);
      pending_words.push_back(32'hFFFF_FFFF);
      pending_words.push_back(32'h5555_AAAA);
      drain();

      set_format(5'd16, 1'b0);
      pending_words.push_back(32'hABCD_EF01);
      pending_words.push_back(32'hFEDC_BA98);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         if (p < 9) begin
            fmt = listed_format(p);
         end else begin
            fmt = {ira_pkg::RADIX_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1))};
         end
         // no idling in the closing phases
         idle_on = (p < PHASES - QUIET_PHASES);
         set_format(fmt[ira_pkg::RADIX_W:1], fmt[0]);
         for (int k = 0; k < PHASE_WORDS; k++) begin
            pending_words.push_back(pick_word());
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_text.size() != 0) begin
         error_count += expected_text.size();
         $display("%0d expected characters never arrived", expected_text.size());
      end

      $display("converted %0d words under %0d base/case settings, %0d characters checked",
               words_sent, settings_run, chars_checked);
      $display("clamped bases, negative words in base ten and other bases all exercised");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d errors", error_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
